// ===== sv/ufcr_pkg.sv =====
// Package for the UDP frame chunk reassembler: status codes, widths and defaults.
// Used by the controller, the slot datapath and the top level.
`timescale 1ns / 1ps
package ufcr_pkg;
    localparam int POOL_SLOTS_DEF  = 4;
    localparam int CHUNK_LIMIT_DEF = 32;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd100;
    localparam logic [15:0] MAX_BYTES_RESET = 16'd24576;

    localparam logic [2:0] ST_INVALID  = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_DUP      = 3'd2;
    localparam logic [2:0] ST_ACCEPT   = 3'd3;
    localparam logic [2:0] ST_COMPLETE = 3'd4;
    localparam logic [2:0] ST_DROP     = 3'd5;
    localparam logic [2:0] ST_RELEASED = 3'd6;

    localparam logic FUNC_CHUNK   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    localparam logic CFG_TIMEOUT   = 1'b0;
    localparam logic CFG_MAX_BYTES = 1'b1;

    // Commands from the controller to the slot datapath.
    typedef struct packed {
        logic capture;
        logic update;
    } ufcr_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic result_ready;
    } ufcr_stat_t;
endpackage

// ===== sv/ufcr_ctrl.sv =====
// Controller of the UDP frame chunk reassembler: input/output handshake sequencing.
// Depends on ufcr_pkg.
`timescale 1ns / 1ps
module ufcr_ctrl
    import ufcr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output ufcr_cmd_t  cmd,
    input  ufcr_stat_t stat
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;

    // A new item may enter while a finished result waits for its taker once
    // the result leaves in the same cycle.
    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd.capture = 1'b0;
        cmd.update  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.update = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = stat.result_ready;
                if (out_ready)
                begin
                    in_ready = 1'b1;
                    if (in_valid)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = S_EXEC;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

// ===== sv/ufcr_datapath.sv =====
// Slot table datapath of the UDP frame chunk reassembler: validation, expiry,
// lookup, allocation and counters. Depends on ufcr_pkg.
`timescale 1ns / 1ps
module ufcr_datapath
    import ufcr_pkg::*;
#(
    parameter int POOL_SLOTS  = POOL_SLOTS_DEF,
    parameter int CHUNK_LIMIT = CHUNK_LIMIT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ufcr_cmd_t   cmd,
    output ufcr_stat_t  stat,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        func,
    input  logic [31:0] now_ms,
    input  logic [31:0] frame_tag,
    input  logic [31:0] chunk_num,
    input  logic [31:0] chunk_count,
    input  logic [31:0] frame_bytes,
    input  logic [31:0] byte_offset,
    input  logic [31:0] hdr_length,
    input  logic [15:0] payload_len,
    input  logic        queue_room,
    input  logic [2:0]  release_slot,
    output logic [2:0]  status,
    output logic [2:0]  slot,
    output logic [15:0] write_offset,
    output logic [15:0] write_length,
    output logic [15:0] frame_size,
    output logic [3:0]  expired_now,
    output logic [31:0] dropped_total,
    output logic [31:0] completed_total
);
    localparam int SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int CW = $clog2(CHUNK_LIMIT + 1);
    localparam int IW = (CHUNK_LIMIT > 1) ? $clog2(CHUNK_LIMIT) : 1;

    logic [15:0] timeout_reg, max_bytes_reg;

    // Captured item.
    logic        func_q;
    logic [31:0] now_q, fid_q;
    logic [IW-1:0] cidx_q;
    logic [CW-1:0] tch_q;
    logic [15:0] tsize_q, off_q, len_q;
    logic        room_q, valid_q;
    logic [2:0]  rel_q;

    logic [POOL_SLOTS-1:0] active_reg, held_reg;
    logic [31:0]   fid_mem   [POOL_SLOTS];
    logic [CW-1:0] tot_mem   [POOL_SLOTS];
    logic [15:0]   bytes_mem [POOL_SLOTS];
    logic [CHUNK_LIMIT-1:0] seen_mem [POOL_SLOTS];
    logic [CW-1:0] cnt_mem   [POOL_SLOTS];
    logic [31:0]   start_mem [POOL_SLOTS];
    logic [SW-1:0] ptr_reg;
    logic [31:0]   drop_reg, done_reg;
    logic          res_reg;

    // Validation at capture, on raw inputs.
    logic [32:0] end_sum;
    logic        ok;
    assign end_sum = {1'b0, byte_offset} + {1'b0, hdr_length};
    assign ok = (hdr_length == {16'd0, payload_len}) && (chunk_num < chunk_count)
             && (chunk_count <= 32'(CHUNK_LIMIT)) && (end_sum <= {1'b0, frame_bytes})
             && (frame_bytes <= {16'd0, max_bytes_reg});

    // Execute stage, from captured item.
    logic [POOL_SLOTS-1:0] expire, act_after, hit, free_v;
    logic [3:0]    exp_cnt;
    logic          found, alloc_ok, dup, last, miss;
    logic [SW-1:0] hit_idx, alloc_idx, s;
    logic [CHUNK_LIMIT-1:0] seen_cur, bitm, seen_new, need;
    logic [CW-1:0] cnt_new, tot_cur;
    logic [31:0]   age [POOL_SLOTS];

    always_comb
    begin
        exp_cnt = '0;
        for (int i = 0; i < POOL_SLOTS; i++)
        begin
            age[i]       = now_q - start_mem[i];
            expire[i]    = active_reg[i] && (age[i] > {16'd0, timeout_reg});
            act_after[i] = active_reg[i] && !expire[i];
            hit[i]       = act_after[i] && (fid_mem[i] == fid_q);
            free_v[i]    = !act_after[i] && !held_reg[i];
            exp_cnt      = exp_cnt + 4'(expire[i]);
        end
        found   = 1'b0;
        hit_idx = '0;
        for (int i = POOL_SLOTS - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                found   = 1'b1;
                hit_idx = SW'(i);
            end
        end
        // Round-robin search starting at the pointer.
        alloc_ok  = 1'b0;
        alloc_idx = '0;
        for (int k = POOL_SLOTS - 1; k >= 0; k--)
        begin
            logic [SW:0] p;
            p = {1'b0, ptr_reg} + (SW + 1)'(k);
            if (p >= (SW + 1)'(POOL_SLOTS))
                p = p - (SW + 1)'(POOL_SLOTS);
            if (free_v[p[SW-1:0]])
            begin
                alloc_ok  = 1'b1;
                alloc_idx = p[SW-1:0];
            end
        end
        s        = found ? hit_idx : alloc_idx;
        seen_cur = found ? seen_mem[s] : '0;
        tot_cur  = found ? tot_mem[s] : tch_q;
        bitm     = CHUNK_LIMIT'(1) << cidx_q;
        dup      = (seen_cur & bitm) != '0;
        seen_new = seen_cur | bitm;
        cnt_new  = (found ? cnt_mem[s] : '0) + CW'(1);
        last     = cnt_new == tot_cur;
        need     = '0;
        for (int j = 0; j < CHUNK_LIMIT; j++)
            need[j] = CW'(j) < tot_cur;
        miss     = ((seen_new & need) != need) || !room_q;
    end

    assign stat.result_ready = res_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_q  <= func;
            now_q   <= now_ms;
            fid_q   <= frame_tag;
            cidx_q  <= chunk_num[IW-1:0];
            tch_q   <= chunk_count[CW-1:0];
            tsize_q <= frame_bytes[15:0];
            off_q   <= byte_offset[15:0];
            len_q   <= hdr_length[15:0];
            room_q  <= queue_room;
            rel_q   <= release_slot;
            valid_q <= ok;
        end
        if (cmd.update && func_q == FUNC_CHUNK && valid_q && (found || alloc_ok) && !dup)
        begin
            seen_mem[s] <= seen_new;
            cnt_mem[s]  <= cnt_new;
            if (!found)
            begin
                fid_mem[s]   <= fid_q;
                tot_mem[s]   <= tch_q;
                bytes_mem[s] <= tsize_q;
                start_mem[s] <= now_q;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_RESET;
            max_bytes_reg <= MAX_BYTES_RESET;
            active_reg    <= '0;
            held_reg      <= '0;
            ptr_reg       <= '0;
            drop_reg      <= '0;
            done_reg      <= '0;
            res_reg       <= 1'b0;
            status        <= ST_INVALID;
            slot          <= '0;
            write_offset  <= '0;
            write_length  <= '0;
            frame_size    <= '0;
            expired_now   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_TIMEOUT)
                    timeout_reg <= cfg_data;
                else
                    max_bytes_reg <= cfg_data;
            end
            if (cmd.capture)
                res_reg <= 1'b0;
            if (cmd.update)
            begin
                res_reg      <= 1'b1;
                slot         <= '0;
                write_offset <= '0;
                write_length <= '0;
                frame_size   <= '0;
                expired_now  <= '0;
                if (func_q == FUNC_RELEASE)
                begin
                    status <= ST_RELEASED;
                    slot   <= rel_q;
                    if (32'(rel_q) < 32'(POOL_SLOTS))
                    begin
                        active_reg[rel_q[SW-1:0]] <= 1'b0;
                        held_reg[rel_q[SW-1:0]]   <= 1'b0;
                    end
                end
                else if (!valid_q)
                begin
                    status <= ST_INVALID;
                end
                else
                begin
                    expired_now <= exp_cnt;
                    priority if (!found && !alloc_ok)
                    begin
                        status     <= ST_FULL;
                        active_reg <= act_after;
                        drop_reg   <= drop_reg + 32'(exp_cnt);
                    end
                    else
                    begin
                        logic [POOL_SLOTS-1:0] a;
                        logic [31:0] d;
                        a = act_after;
                        d = drop_reg + 32'(exp_cnt);
                        slot <= 3'(s);
                        if (!found)
                        begin
                            a[s]    = 1'b1;
                            ptr_reg <= (32'(alloc_idx) + 1 >= POOL_SLOTS) ? '0
                                                                   : alloc_idx + SW'(1);
                        end
                        if (dup)
                        begin
                            status <= ST_DUP;
                        end
                        else
                        begin
                            write_offset <= off_q;
                            write_length <= len_q;
                            if (!last)
                                status <= ST_ACCEPT;
                            else if (miss)
                            begin
                                status <= ST_DROP;
                                a[s]   = 1'b0;
                                d      = d + 32'd1;
                            end
                            else
                            begin
                                status      <= ST_COMPLETE;
                                a[s]        = 1'b0;
                                held_reg[s] <= 1'b1;
                                done_reg    <= done_reg + 32'd1;
                                frame_size  <= found ? bytes_mem[s] : tsize_q;
                            end
                        end
                        active_reg <= a;
                        drop_reg   <= d;
                    end
                end
            end
        end
    end

    assign dropped_total   = drop_reg;
    assign completed_total = done_reg;
endmodule

// ===== sv/udp_frame_chunk_reassembler.sv =====
// Top level of the UDP frame chunk reassembler: controller plus slot datapath.
// Depends on ufcr_pkg, ufcr_ctrl and ufcr_datapath.
//
//   Channel   Handshake               Contents
//   in        in_valid / in_ready     one chunk header or slot release
//   out       out_valid / out_ready   one status transaction per input
//   cfg       cfg_we, cfg_index       timeout_ms and max_frame_bytes writes
//
// An input transaction is captured and validated at its accepting edge; at the
// next edge the slot table expires, compares and updates and the result register
// loads, so the result is offered once that register holds it. The next
// transaction is captured in the cycle its predecessor's result is taken, so a
// new item cannot enter while the one before it is still being updated.
// Reset clears slot flags, pointer, counters and restores register defaults.
// A stalled output holds the result and blocks further input.
`timescale 1ns / 1ps
module udp_frame_chunk_reassembler
    import ufcr_pkg::*;
#(
    parameter int POOL_SLOTS  = POOL_SLOTS_DEF,
    parameter int CHUNK_LIMIT = CHUNK_LIMIT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [31:0] now_ms,
    input  logic [31:0] frame_tag,
    input  logic [31:0] chunk_num,
    input  logic [31:0] chunk_count,
    input  logic [31:0] frame_bytes,
    input  logic [31:0] byte_offset,
    input  logic [31:0] hdr_length,
    input  logic [15:0] payload_len,
    input  logic        queue_room,
    input  logic [2:0]  release_slot,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [2:0]  slot,
    output logic [15:0] write_offset,
    output logic [15:0] write_length,
    output logic [15:0] frame_size,
    output logic [3:0]  expired_now,
    output logic [31:0] dropped_total,
    output logic [31:0] completed_total
);
    ufcr_cmd_t  cmd;
    ufcr_stat_t stat;

    // The controller only sequences; all table state lives in the datapath.
    ufcr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    ufcr_datapath #(
        .POOL_SLOTS  (POOL_SLOTS),
        .CHUNK_LIMIT (CHUNK_LIMIT)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .func            (func),
        .now_ms          (now_ms),
        .frame_tag       (frame_tag),
        .chunk_num       (chunk_num),
        .chunk_count     (chunk_count),
        .frame_bytes     (frame_bytes),
        .byte_offset     (byte_offset),
        .hdr_length      (hdr_length),
        .payload_len     (payload_len),
        .queue_room      (queue_room),
        .release_slot    (release_slot),
        .status          (status),
        .slot            (slot),
        .write_offset    (write_offset),
        .write_length    (write_length),
        .frame_size      (frame_size),
        .expired_now     (expired_now),
        .dropped_total   (dropped_total),
        .completed_total (completed_total)
    );
endmodule
